// ===== hw/rtl/hpq_pkg.sv =====
// Package with the shared constants, codes and types of the max-heap priority queue.
`default_nettype none

package hpq_pkg;

	// Heap geometry and field widths.
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = ADDR_W + 2;
	localparam int KEY_W    = 32;
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 3;

	// Request operation codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT   = 3'd0,
		MODE_EXTRACT  = 3'd1,
		MODE_PEEK     = 3'd2,
		MODE_INCREASE = 3'd3,
		MODE_DELETE   = 3'd4
	} mode_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_EMPTY   = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_BADPOS  = 3'd3,
		STAT_SMALLER = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_SU_RD,
		S_SU_CMP,
		S_SD_RD,
		S_SD_CMP_L,
		S_SD_CMP_R,
		S_DONE
	} state_t;

	// Request to the heap memory: one write and a read of two addresses.
	typedef struct packed {
		logic                    we;
		logic [ADDR_W-1:0]       waddr;
		logic signed [KEY_W-1:0] wdata;
		logic                    re;
		logic [ADDR_W-1:0]       raddr_a;
		logic [ADDR_W-1:0]       raddr_b;
	} mem_req_t;

	// One finished result.
	typedef struct packed {
		logic signed [KEY_W-1:0] value;
		status_t                 status;
		logic [CNT_W-1:0]        count;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hpq_if.sv =====
// Request and result channel interfaces of the max-heap priority queue.
`default_nettype none

interface hpq_req_if
	import hpq_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic signed [KEY_W-1:0] key;
	logic [ADDR_W-1:0]       position;

	modport source (output valid, output mode, output key, output position, input ready);
	modport sink (input valid, input mode, input key, input position, output ready);
endinterface

interface hpq_rsp_if
	import hpq_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic signed [KEY_W-1:0] value;
	logic [STAT_W-1:0]       status;
	logic [CNT_W-1:0]        count;

	modport source (output valid, output value, output status, output count, input ready);
	modport sink (input valid, input value, input status, input count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hpq_mem.sv =====
// Heap key memory: one write port and two registered read ports.
`default_nettype none

module hpq_mem
	import hpq_pkg::*;
(
	input  wire logic                    clk,
	input  mem_req_t                     req,
	output logic signed [KEY_W-1:0]      rd_a,
	output logic signed [KEY_W-1:0]      rd_b
);

	logic signed [KEY_W-1:0] mem_q [CAPACITY];
	logic signed [KEY_W-1:0] rd_a_q;
	logic signed [KEY_W-1:0] rd_b_q;

	// Write and read the array; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_a_q <= mem_q[req.raddr_a];
			rd_b_q <= mem_q[req.raddr_b];
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hpq_ctrl.sv =====
// Sequencer of the heap operations around one shared signed key comparator.
`default_nettype none

module hpq_ctrl
	import hpq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	hpq_req_if.sink                 req,
	output mem_req_t                mem_req,
	input  wire logic signed [KEY_W-1:0] rd_a,
	input  wire logic signed [KEY_W-1:0] rd_b,
	output result_t                 res,
	output logic                    res_valid,
	input  wire logic               res_ready
);

	state_t                  state_q, state_d;
	mode_t                   op_q, op_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [ADDR_W-1:0]       pos_q, pos_d;
	logic [ADDR_W-1:0]       big_q, big_d;
	logic signed [KEY_W-1:0] v_q, v_d;
	logic signed [KEY_W-1:0] bv_q, bv_d;
	logic signed [KEY_W-1:0] value_q, value_d;
	status_t                 status_q, status_d;

	logic signed [KEY_W-1:0] cmp_a, cmp_b;
	logic                    cmp_gt;
	logic [CNT_W-1:0]        last_w;
	logic [ADDR_W-1:0]       req_parent;
	logic [ADDR_W-1:0]       pos_parent;
	logic [CHILD_W-1:0]      left_w, right_w, count_ext;
	logic                    sel_r;
	logic [ADDR_W-1:0]       new_big;
	logic signed [KEY_W-1:0] new_bv;

	// The one key comparator that all key comparisons of every operation share.
	assign cmp_gt = cmp_a > cmp_b;

	// Index arithmetic of the heap tree.
	assign last_w     = count_q - CNT_W'(1);
	assign req_parent = (req.position - ADDR_W'(1)) >> 1;
	assign pos_parent = (pos_q - ADDR_W'(1)) >> 1;
	assign left_w     = {1'b0, pos_q, 1'b1};
	assign right_w    = left_w + CHILD_W'(1);
	assign count_ext  = CHILD_W'(count_q);

	// Right child selection in the second compare step of a sift down.
	assign sel_r   = (right_w < count_ext) && cmp_gt;
	assign new_big = sel_r ? right_w[ADDR_W-1:0] : big_q;
	assign new_bv  = sel_r ? rd_b : bv_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Working registers of the current operation.
	always_ff @(posedge clk) begin
		op_q     <= op_d;
		pos_q    <= pos_d;
		big_q    <= big_d;
		v_q      <= v_d;
		bv_q     <= bv_d;
		value_q  <= value_d;
		status_q <= status_d;
	end

	// Next state, memory accesses and comparator operands.
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		count_d   = count_q;
		pos_d     = pos_q;
		big_d     = big_q;
		v_d       = v_q;
		bv_d      = bv_q;
		value_d   = value_q;
		status_d  = status_q;
		mem_req   = '0;
		cmp_a     = rd_a;
		cmp_b     = v_q;
		req.ready = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					op_d     = mode_t'(req.mode);
					pos_d    = req.position;
					v_d      = req.key;
					value_d  = '0;
					status_d = STAT_OK;
					state_d  = S_DONE;
					unique case (mode_t'(req.mode))
						MODE_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_d = STAT_FULL;
							end else begin
								pos_d   = count_q[ADDR_W-1:0];
								count_d = count_q + CNT_W'(1);
								state_d = S_SU_RD;
							end
						end
						MODE_EXTRACT: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								mem_req.re      = 1'b1;
								mem_req.raddr_a = '0;
								mem_req.raddr_b = last_w[ADDR_W-1:0];
								count_d         = last_w;
								state_d         = S_FETCH;
							end
						end
						MODE_PEEK: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								mem_req.re      = 1'b1;
								mem_req.raddr_a = '0;
								state_d         = S_FETCH;
							end
						end
						MODE_INCREASE: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else if (CNT_W'(req.position) >= count_q) begin
								status_d = STAT_BADPOS;
							end else begin
								mem_req.re      = 1'b1;
								mem_req.raddr_a = req.position;
								state_d         = S_FETCH;
							end
						end
						MODE_DELETE: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else if (CNT_W'(req.position) >= count_q) begin
								status_d = STAT_BADPOS;
							end else begin
								count_d = last_w;
								if (CNT_W'(req.position) != last_w) begin
									mem_req.re      = 1'b1;
									mem_req.raddr_a = req_parent;
									mem_req.raddr_b = last_w[ADDR_W-1:0];
									state_d         = S_FETCH;
								end
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			// First read data of the operation has arrived.
			S_FETCH: begin
				state_d = S_DONE;
				unique case (op_q)
					MODE_EXTRACT: begin
						value_d = rd_a;
						v_d     = rd_b;
						pos_d   = '0;
						state_d = S_SD_RD;
					end
					MODE_PEEK: begin
						value_d = rd_a;
					end
					MODE_INCREASE: begin
						cmp_a = rd_a;
						cmp_b = v_q;
						if (cmp_gt) begin
							status_d = STAT_SMALLER;
						end else begin
							state_d = S_SU_RD;
						end
					end
					MODE_DELETE: begin
						v_d   = rd_b;
						cmp_a = rd_b;
						cmp_b = rd_a;
						if (pos_q != '0 && cmp_gt) begin
							state_d = S_SU_RD;
						end else begin
							state_d = S_SD_RD;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			// Sift up: fetch the parent, or settle the key at the root.
			S_SU_RD: begin
				if (pos_q == '0) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_q;
					mem_req.wdata = v_q;
					state_d       = S_DONE;
				end else begin
					mem_req.re      = 1'b1;
					mem_req.raddr_a = pos_parent;
					state_d         = S_SU_CMP;
				end
			end

			// Sift up: move the parent down or settle the key here.
			S_SU_CMP: begin
				cmp_a         = v_q;
				cmp_b         = rd_a;
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				if (cmp_gt) begin
					mem_req.wdata = rd_a;
					pos_d         = pos_parent;
					state_d       = S_SU_RD;
				end else begin
					mem_req.wdata = v_q;
					state_d       = S_DONE;
				end
			end

			// Sift down: fetch both children, or settle at a leaf.
			S_SD_RD: begin
				if (left_w >= count_ext) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_q;
					mem_req.wdata = v_q;
					state_d       = S_DONE;
				end else begin
					mem_req.re      = 1'b1;
					mem_req.raddr_a = left_w[ADDR_W-1:0];
					mem_req.raddr_b = right_w[ADDR_W-1:0];
					state_d         = S_SD_CMP_L;
				end
			end

			// Sift down: left child against the key.
			S_SD_CMP_L: begin
				cmp_a = rd_a;
				cmp_b = v_q;
				if (cmp_gt) begin
					big_d = left_w[ADDR_W-1:0];
					bv_d  = rd_a;
				end else begin
					big_d = pos_q;
					bv_d  = v_q;
				end
				state_d = S_SD_CMP_R;
			end

			// Sift down: right child against the larger so far, then move down or settle the key here.
			S_SD_CMP_R: begin
				cmp_a         = rd_b;
				cmp_b         = bv_q;
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				if (new_big == pos_q) begin
					mem_req.wdata = v_q;
					state_d       = S_DONE;
				end else begin
					mem_req.wdata = new_bv;
					pos_d         = new_big;
					state_d       = S_SD_RD;
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.value  = value_q;
	assign res.status = status_q;
	assign res.count  = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/max_heap_priority_queue.sv =====
// Top level of the max-heap priority queue: sequencer, key memory and result register.
//
// Usage: a request beat on req carries mode, key and position; each request gives
// exactly one result beat on rsp with value, status and the count after the operation.
// The block handles one request at a time: req.ready is high only while the sequencer
// is idle, and drops for the whole operation after a beat is accepted.
// Failed, trivial and no-operation requests go straight to the result; peek reads
// the root; insert sifts the new key up from the end of the heap; increase checks
// that the new key is not smaller than the old one and then sifts it up; extract
// moves the last key to the root and sifts it down; delete moves the last key into
// the freed position and sifts it up or down.
// The sequencer is idle again, and takes the next request, in the cycle after the
// result register is loaded.
// Each level of a sift costs one memory read, then one or two passes through the
// single shared key comparator, with the write of the moved key in the last pass.
// Reset clears the count and the sequencer; the key memory is not cleared, and only
// keys at positions below the count are ever used.
// The result sits in an output register. A stalled receiver holds it there, and the
// sequencer finishes its next operation and then waits with that result until the
// register is free.
`default_nettype none

module max_heap_priority_queue
	import hpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	hpq_req_if.sink   req,
	hpq_rsp_if.source rsp
);

	mem_req_t                mem_req;
	logic signed [KEY_W-1:0] rd_a;
	logic signed [KEY_W-1:0] rd_b;
	result_t                 res;
	logic                    res_valid;
	logic                    res_ready;
	logic                    out_valid_q;
	result_t                 out_res_q;

	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_req   (mem_req),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	hpq_mem u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	// Output register: free when empty or when its beat is taken this cycle.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.value  = out_res_q.value;
	assign rsp.status = out_res_q.status;
	assign rsp.count  = out_res_q.count;

	// The count never goes beyond the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.count <= CNT_W'(CAPACITY)))
		else $error("result count above capacity");

	// A full status is only reported with a full heap.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STAT_FULL) |-> (rsp.count == CNT_W'(CAPACITY)))
		else $error("full status with spare room");

	// An empty status comes with a zero value and a zero count.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STAT_EMPTY) |-> (rsp.value == '0 && rsp.count == '0))
		else $error("empty status with nonzero value or count");

	// An accepted request keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while an operation is in progress");

	// A finished result always lands in the output register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid_q)
		else $error("finished result lost");

endmodule

`default_nettype wire
